>>> sv/rapq_pkg.sv
// Shared types and constants of the range-assign, point-query segment tree.
// Depends on nothing; the top level, the checker and the testbench use it.
package rapq_pkg;

   localparam int DEFAULT_LEAVES = 1024;
   localparam int VALUE_W        = 31;
   localparam int STAMP_W        = 32;
   localparam int NODE_W         = STAMP_W + VALUE_W;

   localparam logic [VALUE_W-1:0] INIT_VALUE = {VALUE_W{1'b1}};

   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_STAMP = 2'd2
   } status_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [VALUE_W-1:0] value;
   } node_type;

endpackage

>>> sv/range_assign_point_query_tree.sv
// Top level of the range-assign, point-query segment tree.
// Depends on rapq_pkg and rapq_ram.
//
//   channel   direction  transfer happens when    payload
//   req_      in         start && !busy           operation, range bounds, value, index
//   rsp_      out        rsp_valid (one cycle)    read_value, status
//
// After reset the block sweeps the node memory, one node per cycle, with busy high
// until all 2*SPAN nodes are written (2048 at the default of 1024 leaves; SPAN is LEAVES
// rounded up to a power of two). Reset is synchronous and active high.
// An assign takes a left step and a right step per tree level that the bounds climb,
// each step writing at most one node.
// A query reads one node per level on the single read port, from the leaf up to the
// root; each read's registered data is compared in the next cycle, and after the root's
// the result register loads as busy falls.
// Rejected items give their result in the next cycle and keep busy low.
// Each result shows for exactly one cycle; the receiver cannot stall it.
module range_assign_point_query_tree #(
   parameter int LEAVES = rapq_pkg::DEFAULT_LEAVES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_operation,
   input  logic [9:0]                   req_range_low,
   input  logic [10:0]                  req_range_end,
   input  logic [rapq_pkg::VALUE_W-1:0] req_write_value,
   input  logic [9:0]                   req_query_index,
   output logic                         rsp_valid,
   output logic [rapq_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [1:0]                   rsp_status
);

   // The tree is stored heap style: node 1 is the root, leaves sit at
   // SPAN..2*SPAN-1 and node 0 is never used.
   localparam int SPAN  = 1 << $clog2(LEAVES);
   localparam int DEPTH = 2 * SPAN;
   localparam int AW    = $clog2(DEPTH);
   // Bound registers need one more bit: the right bound can reach 2*SPAN.
   localparam int RW    = AW + 1;

   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_A_LEFT  = 5'b00100,
      ST_A_RIGHT = 5'b01000,
      ST_Q_WALK  = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic [rapq_pkg::STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [RW-1:0]                  l_ff, l_in;
   logic [RW-1:0]                  r_ff, r_in;
   logic [RW-1:0]                  r_dec;
   logic [rapq_pkg::VALUE_W-1:0]   val_ff, val_in;
   logic [AW-1:0]                  q_ff, q_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic                           rd_last_ff, rd_last_in;
   rapq_pkg::node_type             best_ff, best_in, best_sel;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rapq_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   rapq_pkg::status_type           rsp_status_ff, rsp_status_in;

   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   rapq_pkg::node_type             wr_data;
   logic                           rd_en;
   rapq_pkg::node_type             rd_data;
   logic                           range_bad;

   rapq_ram #(
      .WIDTH (rapq_pkg::NODE_W),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (q_ff),
      .rd_data (rd_data)
   );

   assign r_dec = r_ff - RW'(1);

   // An assign is empty or runs past the last leaf.
   assign range_bad = ({1'b0, req_range_low} >= req_range_end) ||
                      ({21'd0, req_range_end} > 32'(LEAVES));

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      stamp_in      = stamp_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      val_in        = val_ff;
      q_in          = q_ff;
      rd_vld_in     = 1'b0;
      rd_last_in    = 1'b0;
      best_in       = best_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = l_ff[AW-1:0];
      wr_data       = '{stamp: stamp_ff, value: val_ff};
      rd_en         = 1'b0;

      // The incoming node replaces the best one only on a strictly newer stamp.
      if (rd_data.stamp > best_ff.stamp) begin
         best_sel = rd_data;
      end else begin
         best_sel = best_ff;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '{stamp: '0, value: rapq_pkg::INIT_VALUE};
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_operation == rapq_pkg::OP_ASSIGN) begin
                  if (range_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = rapq_pkg::STATUS_RANGE;
                  end else if (stamp_ff == {rapq_pkg::STAMP_W{1'b1}}) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = rapq_pkg::STATUS_STAMP;
                  end else begin
                     stamp_in = stamp_ff + rapq_pkg::STAMP_W'(1);
                     l_in     = RW'(req_range_low) + RW'(SPAN);
                     r_in     = RW'(req_range_end) + RW'(SPAN);
                     val_in   = req_write_value;
                     state_in = ST_A_LEFT;
                  end
               end else begin
                  if ({22'd0, req_query_index} >= 32'(LEAVES)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = rapq_pkg::STATUS_RANGE;
                  end else begin
                     q_in     = AW'(SPAN) + AW'(req_query_index);
                     best_in  = '{stamp: '0, value: rapq_pkg::INIT_VALUE};
                     state_in = ST_Q_WALK;
                  end
               end
            end
         end
         ST_A_LEFT: begin
            if (l_ff < r_ff) begin
               wr_en    = l_ff[0];
               wr_addr  = l_ff[AW-1:0];
               l_in     = (l_ff + RW'(l_ff[0])) >> 1;
               state_in = ST_A_RIGHT;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = rapq_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         ST_A_RIGHT: begin
            wr_en    = r_ff[0];
            wr_addr  = r_dec[AW-1:0];
            r_in     = r_ff >> 1;
            state_in = ST_A_LEFT;
         end
         ST_Q_WALK: begin
            // Reads are issued one level per cycle; the data of each read
            // is compared in the next cycle. The root is the last node read.
            if (q_ff != '0) begin
               rd_en      = 1'b1;
               q_in       = q_ff >> 1;
               rd_vld_in  = 1'b1;
               rd_last_in = (q_ff == AW'(1));
            end
            if (rd_vld_ff) begin
               best_in = best_sel;
               if (rd_last_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = best_sel.value;
                  rsp_status_in = rapq_pkg::STATUS_OK;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         stamp_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         stamp_ff     <= stamp_in;
         rd_vld_ff    <= rd_vld_in;
         rd_last_ff   <= rd_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff          <= l_in;
      r_ff          <= r_in;
      val_ff        <= val_in;
      q_ff          <= q_in;
      best_ff       <= best_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

>>> sv/rapq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module rapq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/rapq_checker.sv
// Port-level checks of the segment tree, attached to the top level by bind.
// Depends on rapq_pkg and range_assign_point_query_tree.
module rapq_checker #(
   parameter int LEAVES = rapq_pkg::DEFAULT_LEAVES
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_operation,
   input logic [9:0]                   req_query_index,
   input logic                         rsp_valid,
   input logic [rapq_pkg::VALUE_W-1:0] rsp_read_value,
   input logic [1:0]                   rsp_status
);

   // A query past the last leaf is answered at once with a range error.
   a_query_range: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == rapq_pkg::OP_QUERY &&
       {22'd0, req_query_index} >= 32'(LEAVES))
      |=> (rsp_valid && rsp_status == rapq_pkg::STATUS_RANGE && !busy))
      else $error("out-of-range query not answered with a range error");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == rapq_pkg::STATUS_OK ||
                     rsp_status == rapq_pkg::STATUS_RANGE ||
                     rsp_status == rapq_pkg::STATUS_STAMP))
      else $error("undefined status code on the response");

   // Refused items carry a zero value.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != rapq_pkg::STATUS_OK) |-> (rsp_read_value == '0))
      else $error("refused item returned a nonzero value");

   // The block only goes busy after a transfer on the request side.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted request");

endmodule

bind range_assign_point_query_tree rapq_checker #(.LEAVES(LEAVES)) u_rapq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_operation   (req_operation),
   .req_query_index (req_query_index),
   .rsp_valid       (rsp_valid),
   .rsp_read_value  (rsp_read_value),
   .rsp_status      (rsp_status)
);

>>> tb/tb_range_assign_point_query_tree.sv
`timescale 1ns / 1ps
// Self-checking testbench of range_assign_point_query_tree: directed and random assigns
// and queries, checked against a shadow segment tree. Depends on rapq_pkg and the block.
module tb_range_assign_point_query_tree;
   import rapq_pkg::*;

   localparam int LEAVES      = DEFAULT_LEAVES;
   localparam int SPAN        = 1024;           // LEAVES rounded up to a power of two
   localparam int NODES       = 2 * SPAN;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_ITEMS = 450;
   localparam int QUIET_FROM  = 400;            // no idling from this item on
   localparam int DRAIN_AT    = 220;            // the sender waits for every result here
   localparam int SETTLE_CYCLES = 40;           // longer than the slowest item of the block

   typedef struct {
      logic [VALUE_W-1:0] read_value;
      status_type         status;
   } answer_type;

   // The scoreboard keeps its own copy of the tree and the stamp counter. Each
   // accepted transfer is applied to that copy at once, so the answer it queues is
   // what the block must return for that item, in order.
   class tree_scoreboard;
      logic [STAMP_W-1:0] node_stamp [NODES];
      logic [VALUE_W-1:0] node_value [NODES];
      logic [STAMP_W-1:0] stamp_count;
      answer_type         pending [$];
      int                 mismatches;

      function new();
         for (int i = 0; i < NODES; i++) begin
            node_stamp[i] = '0;
            node_value[i] = INIT_VALUE;
         end
         stamp_count = '0;
         mismatches  = 0;
      endfunction

      function void note_transfer(input logic op, input logic [9:0] lo, input logic [10:0] hi,
                                  input logic [VALUE_W-1:0] val, input logic [9:0] qi);
         answer_type         ans;
         int unsigned        l;
         int unsigned        r;
         int unsigned        idx;
         logic [STAMP_W-1:0] best_stamp;
         ans.read_value = '0;
         ans.status     = STATUS_OK;
         if (op == OP_ASSIGN) begin
            // The range test comes first; a refused assign leaves the stamp alone.
            if (lo >= hi || hi > LEAVES) begin
               ans.status = STATUS_RANGE;
            end else if (stamp_count == '1) begin
               ans.status = STATUS_STAMP;
            end else begin
               stamp_count++;
               l = lo + SPAN;
               r = hi + SPAN;
               while (l < r) begin
                  if ((l & 1) != 0) begin
                     node_stamp[l] = stamp_count;
                     node_value[l] = val;
                     l++;
                  end
                  l = l >> 1;
                  if ((r & 1) != 0) begin
                     r--;
                     node_stamp[r] = stamp_count;
                     node_value[r] = val;
                  end
                  r = r >> 1;
               end
            end
         end else if (qi >= LEAVES) begin
            ans.status = STATUS_RANGE;
         end else begin
            // Climb from the leaf; only a strictly newer stamp takes over.
            idx            = qi + SPAN;
            best_stamp     = node_stamp[idx];
            ans.read_value = node_value[idx];
            while (idx > 1) begin
               idx = idx >> 1;
               if (node_stamp[idx] > best_stamp) begin
                  best_stamp     = node_stamp[idx];
                  ans.read_value = node_value[idx];
               end
            end
         end
         pending.push_back(ans);
      endfunction

      function void check_result(input logic [VALUE_W-1:0] rv, input logic [1:0] st);
         answer_type ans;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with nothing outstanding: value %0d status %0d",
                        $realtime, rv, st);
            return;
         end
         ans = pending.pop_front();
         if (rv !== ans.read_value || st !== ans.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: mismatch: expected value %0d status %0d, got value %0d status %0d",
                        $realtime, ans.read_value, ans.status, rv, st);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_operation;
   logic [9:0]         req_range_low;
   logic [10:0]        req_range_end;
   logic [VALUE_W-1:0] req_write_value;
   logic [9:0]         req_query_index;
   logic               rsp_valid;
   logic [VALUE_W-1:0] rsp_read_value;
   logic [1:0]         rsp_status;

   tree_scoreboard sb = new();

   range_assign_point_query_tree #(
      .LEAVES(LEAVES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_range_low   (req_range_low),
      .req_range_end   (req_range_end),
      .req_write_value (req_write_value),
      .req_query_index (req_query_index),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Results are sampled at the edge that ends their cycle; the values seen here
   // are the ones from before the edge, since the block updates with nonblocking
   // assignments.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1)
         sb.check_result(rsp_read_value, rsp_status);
   end

   // Puts one item on the request ports and holds it until the transfer. The caller
   // is just past a rising edge, so every drive here lands at an edge. When the next
   // item follows at once, start gets a single assignment of 1 in that step.
   task automatic send_item(input logic op, input logic [9:0] lo, input logic [10:0] hi,
                            input logic [VALUE_W-1:0] val, input logic [9:0] qi);
      start           <= 1'b1;
      req_operation   <= op;
      req_range_low   <= lo;
      req_range_end   <= hi;
      req_write_value <= val;
      req_query_index <= qi;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      sb.note_transfer(op, lo, hi, val, qi);
   endtask

   initial begin : stimulus
      logic               op;
      logic [9:0]         lo;
      logic [10:0]        hi;
      logic [VALUE_W-1:0] val;
      logic [9:0]         qi;
      logic [9:0]         last_lo;
      logic [10:0]        last_hi;
      int                 len;
      int                 pick;
      bit                 idle_on;

      reset           <= 1'b1;
      start           <= 1'b0;
      req_operation   <= OP_ASSIGN;
      req_range_low   <= '0;
      req_range_end   <= '0;
      req_write_value <= '0;
      req_query_index <= '0;
      last_lo = '0;
      last_hi = 11'd1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The block clears its memory first, so the first transfer
      // waits out that sweep. Fields an operation does not use carry random bits.
      // The first two queries see the value left by reset.
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd0);
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd1023);
      // The whole tree is covered by the root alone.
      send_item(OP_ASSIGN, 10'd0, 11'd1024, '0, 10'($urandom));
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd0);
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd512);
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd1023);
      // First leaf gets the top value; then the last leaf and the deepest split cover.
      send_item(OP_ASSIGN, 10'd0, 11'd1, INIT_VALUE, 10'($urandom));
      send_item(OP_ASSIGN, 10'd1023, 11'd1024, 31'h5555_5555, 10'($urandom));
      send_item(OP_ASSIGN, 10'd1, 11'd1023, 31'h2AAA_AAAA, 10'($urandom));
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd0);
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd1);
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd1022);
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd1023);
      // Empty ranges: equal bounds, and an end below the start.
      send_item(OP_ASSIGN, 10'd5, 11'd5, VALUE_W'($urandom), 10'($urandom));
      send_item(OP_ASSIGN, 10'd1023, 11'd0, VALUE_W'($urandom), 10'($urandom));
      // Ranges that run past the last position.
      send_item(OP_ASSIGN, 10'd0, 11'd1025, VALUE_W'($urandom), 10'($urandom));
      send_item(OP_ASSIGN, 10'd1023, 11'd2047, VALUE_W'($urandom), 10'($urandom));
      // A refused assign must not have disturbed the tree.
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd5);
      send_item(OP_ASSIGN, 10'd300, 11'd301, 31'd1, 10'($urandom));
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd299);
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd300);
      send_item(OP_QUERY, 10'($urandom), 11'($urandom), VALUE_W'($urandom), 10'd301);
      // Running the stamp counter out takes four billion assigns, far beyond any
      // run; the scoreboard still models the refusal.

      // Random part. Most items are valid assigns and queries, many of the queries
      // close to the bounds of the last assign, where cover nodes meet.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == DRAIN_AT) begin
            start <= 1'b0;
            while (sb.pending.size() != 0)
               @(posedge clock);
         end else if (i < QUIET_FROM) begin
            // Stretches of bursty idling alternate with stretches of none.
            idle_on = ((i / 50) % 2) == 0;
            if (idle_on && $urandom_range(0, 2) == 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 10)) @(posedge clock);
            end
         end

         val  = VALUE_W'($urandom);
         if ($urandom_range(0, 15) == 0)
            val = $urandom_range(0, 1) ? INIT_VALUE : '0;
         lo   = 10'($urandom);
         hi   = 11'($urandom);
         qi   = 10'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            op = OP_ASSIGN;
            case ($urandom_range(0, 3))
               0:       len = $urandom_range(1, 16);
               1:       len = $urandom_range(1, 128);
               2:       len = $urandom_range(1, 1024);
               default: len = 1024;
            endcase
            if ($urandom_range(0, 7) == 0)
               lo = '0;
            if (lo + len > 1024)
               hi = 11'd1024;
            else
               hi = 11'(lo + len);
            last_lo = lo;
            last_hi = hi;
         end else if (pick < 55) begin
            op = OP_ASSIGN;
            if ($urandom_range(0, 1) == 0)
               hi = 11'($urandom_range(0, lo));
            else
               hi = 11'($urandom_range(1025, 2047));
         end else begin
            op = OP_QUERY;
            case ($urandom_range(0, 4))
               0:       qi = last_lo;
               1:       qi = last_lo - 10'd1;
               2:       qi = 10'(last_hi - 11'd1);
               3:       qi = 10'(last_hi);
               default: qi = 10'($urandom);
            endcase
         end
         send_item(op, lo, hi, val, qi);
      end
      start <= 1'b0;

      while (sb.pending.size() != 0)
         @(posedge clock);
      // Stray results would show up within the longest item time.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // A watchdog far beyond the slowest correct run: the clearing sweep plus every item
   // at its longest time and the longest sender gap.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
